// ===== hdl/tds_pkg.sv =====
package tds_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ROW_W         = 6;
    localparam int STAT_W        = 2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_PIVOT = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;
    localparam logic [STAT_W-1:0] ST_ROWS  = 2'd3;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } sat_val_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sub;
        logic first;
        logic div_start;
        logic we;
        logic x_from_rhs;
        logic clr_x;
        logic bk_mul;
        logic bk_sub;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_done;
        logic fwd_sat;
        logic bk_sat;
    } dp_stat_t;

    // clamp a wide signed value to 32 bits
    function automatic sat_val_t sat32(input logic signed [63:0] v);
        sat_val_t res;
        res.sat = !((&v[63:31]) || !(|v[63:31]));
        if (res.sat)
        begin
            res.val = v[63] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        else
        begin
            res.val = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/tds_if.sv =====
interface tds_row_if;
    logic        valid;
    logic        ready;
    logic [31:0] sub_diag;
    logic [31:0] main_diag;
    logic [31:0] super_diag;
    logic [31:0] rhs_value;
    logic        last_row;

    modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    input ready);
    modport sink (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                  output ready);
endinterface

interface tds_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  row_index;
    logic [31:0] solution;
    logic        final_value;
    logic [1:0]  status;

    modport source (output valid, row_index, solution, final_value, status, input ready);
    modport sink (input valid, row_index, solution, final_value, status, output ready);
endinterface

// ===== hdl/tds_ram.sv =====
module tds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/tds_div.sv =====
module tds_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot,
    output logic        sat
);
    import tds_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int KW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [31:0]   rem_reg, rem_next;
    logic [NW-1:0] dvd_reg, dvd_next;
    logic [31:0]   dmag_reg, dmag_next;
    logic          neg_reg, neg_next;
    logic [32:0]   rem_sh;
    logic [32:0]   trial;
    logic [31:0]   nmag;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        nmag      = num[31] ? (~num + 32'd1) : num;
        rem_sh    = {rem_reg, dvd_reg[NW-1]};
        trial     = rem_sh - {1'b0, dmag_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = KW'(NW);
            rem_next  = '0;
            dvd_next  = {nmag, {FRAC_BITS{1'b0}}};
            dmag_next = den[31] ? (~den + 32'd1) : den;
            neg_next  = num[31] ^ den[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                dvd_next = {dvd_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                dvd_next = {dvd_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - KW'(1);
            if (cnt_reg == KW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    always_comb
    begin
        if (neg_reg)
        begin
            sat  = (|dvd_reg[NW-1:32]) || (dvd_reg[31] && (|dvd_reg[30:0]));
            quot = sat ? 32'h8000_0000 : (~dvd_reg[31:0] + 32'd1);
        end
        else
        begin
            sat  = |dvd_reg[NW-1:31];
            quot = sat ? 32'h7fff_ffff : dvd_reg[31:0];
        end
    end

    assign done = done_reg;
endmodule

// ===== hdl/tds_datapath.sv =====
module tds_datapath #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  tds_pkg::dp_cmd_t                             cmd,
    output tds_pkg::dp_stat_t                            stat,
    input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr,
    input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] wr_addr,
    input  logic [31:0]                                  sub_diag,
    input  logic [31:0]                                  main_diag,
    input  logic [31:0]                                  super_diag,
    input  logic [31:0]                                  rhs_value,
    output logic [31:0]                                  solution
);
    import tds_pkg::*;

    logic signed [31:0] a_reg, b_reg, c_reg, r_reg;
    logic signed [31:0] den_reg, num_reg, x_reg;
    logic signed [63:0] p1_reg, p2_reg;
    logic               sub_sat_reg;
    logic [31:0]        rd_super, rd_rhs;
    logic [31:0]        q_super, q_rhs;
    logic               sat_super, sat_rhs, done_super, done_rhs;
    logic signed [31:0] mul_a;
    sat_val_t           m1, m2, d1, d2, bm, bd;

    tds_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_super_ram (
        .clk(clk), .we(cmd.we), .wr_addr(wr_addr), .wr_data(q_super),
        .rd_addr(rd_addr), .rd_data(rd_super)
    );

    tds_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rhs_ram (
        .clk(clk), .we(cmd.we), .wr_addr(wr_addr), .wr_data(q_rhs),
        .rd_addr(rd_addr), .rd_data(rd_rhs)
    );

    tds_div #(.FRAC_BITS(FRAC_BITS)) u_div_super (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(c_reg), .den(den_reg),
        .done(done_super), .quot(q_super), .sat(sat_super)
    );

    tds_div #(.FRAC_BITS(FRAC_BITS)) u_div_rhs (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(num_reg), .den(den_reg),
        .done(done_rhs), .quot(q_rhs), .sat(sat_rhs)
    );

    assign mul_a = cmd.bk_mul ? x_reg : a_reg;

    always_comb
    begin
        m1 = sat32(p1_reg >>> FRAC_BITS);
        m2 = sat32(p2_reg >>> FRAC_BITS);
        d1 = sat32(64'(b_reg) - 64'($signed(m1.val)));
        d2 = sat32(64'(r_reg) - 64'($signed(m2.val)));
        bm = m1;
        bd = sat32(64'($signed(rd_rhs)) - 64'($signed(bm.val)));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= sub_diag;
            b_reg <= main_diag;
            c_reg <= super_diag;
            r_reg <= rhs_value;
        end
        if (cmd.mul || cmd.bk_mul)
        begin
            p1_reg <= mul_a * $signed(rd_super);
            p2_reg <= a_reg * $signed(rd_rhs);
        end
        if (cmd.sub)
        begin
            if (cmd.first)
            begin
                den_reg     <= b_reg;
                num_reg     <= r_reg;
                sub_sat_reg <= 1'b0;
            end
            else
            begin
                den_reg     <= d1.val;
                num_reg     <= d2.val;
                sub_sat_reg <= m1.sat | m2.sat | d1.sat | d2.sat;
            end
        end
        if (cmd.clr_x)
        begin
            x_reg <= '0;
        end
        else if (cmd.x_from_rhs)
        begin
            x_reg <= q_rhs;
        end
        else if (cmd.bk_sub)
        begin
            x_reg <= bd.val;
        end
    end

    assign stat.den_zero = (den_reg == 32'sd0);
    assign stat.div_done = done_super & done_rhs;
    assign stat.fwd_sat  = sub_sat_reg | sat_super | sat_rhs;
    assign stat.bk_sat   = bm.sat | bd.sat;
    assign solution      = x_reg;
endmodule

// ===== hdl/tds_ctrl.sv =====
module tds_ctrl #(
    parameter int MAX_ROWS = 64
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         row_valid,
    input  logic                                         row_last,
    output logic                                         row_ready,
    output logic                                         res_valid,
    input  logic                                         res_ready,
    output logic [tds_pkg::ROW_W-1:0]                    res_row,
    output logic                                         res_final,
    output logic [tds_pkg::STAT_W-1:0]                   res_status,
    output tds_pkg::dp_cmd_t                             cmd,
    input  tds_pkg::dp_stat_t                            stat,
    output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr,
    output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] wr_addr
);
    import tds_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_SUB  = 9'b000000100,
        S_CHK  = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_WR   = 9'b000100000,
        S_OUT  = 9'b001000000,
        S_BMUL = 9'b010000000,
        S_BSUB = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       rows_reg, rows_next;
    logic [CW-1:0]       row_reg, row_next;
    logic [STAT_W-1:0]   err_reg, err_next;
    logic                last_reg, last_next;
    logic                sat_reg, sat_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic                final_reg, final_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic                fatal;
    logic [CW-1:0]       addr_full;

    assign fatal = (err_reg == ST_PIVOT) || (err_reg == ST_ROWS);

    always_comb
    begin
        state_next   = state_reg;
        rows_next    = rows_reg;
        row_next     = row_reg;
        err_next     = err_reg;
        last_next    = last_reg;
        sat_next     = sat_reg;
        out_row_next = out_row_reg;
        final_next   = final_reg;
        status_next  = status_reg;
        cmd          = '0;
        row_ready    = 1'b0;
        res_valid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                row_ready = 1'b1;
                if (row_valid)
                begin
                    cmd.load  = 1'b1;
                    last_next = row_last;
                    if (rows_reg >= CW'(MAX_ROWS) || fatal)
                    begin
                        if (rows_reg >= CW'(MAX_ROWS))
                        begin
                            if (!fatal)
                            begin
                                err_next = ST_ROWS;
                            end
                        end
                        else
                        begin
                            rows_next = rows_reg + CW'(1);
                        end
                        if (row_last)
                        begin
                            cmd.clr_x    = 1'b1;
                            out_row_next = '0;
                            final_next   = 1'b1;
                            status_next  = err_next;
                            state_next   = S_OUT;
                        end
                    end
                    else
                    begin
                        rows_next  = rows_reg + CW'(1);
                        row_next   = rows_reg;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                cmd.first  = (row_reg == '0);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.den_zero)
                begin
                    err_next = ST_PIVOT;
                    if (last_reg)
                    begin
                        cmd.clr_x    = 1'b1;
                        out_row_next = '0;
                        final_next   = 1'b1;
                        status_next  = ST_PIVOT;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.we = 1'b1;
                if (stat.fwd_sat && err_reg == ST_OK)
                begin
                    err_next = ST_SAT;
                end
                if (last_reg)
                begin
                    cmd.x_from_rhs = 1'b1;
                    sat_next       = (err_next == ST_SAT);
                    out_row_next   = ROW_W'(row_reg);
                    final_next     = (row_reg == '0);
                    status_next    = sat_next ? ST_SAT : ST_OK;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (final_reg)
                    begin
                        rows_next  = '0;
                        err_next   = ST_OK;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg - CW'(1);
                        state_next = S_BMUL;
                    end
                end
            end
            S_BMUL:
            begin
                cmd.bk_mul = 1'b1;
                state_next = S_BSUB;
            end
            S_BSUB:
            begin
                cmd.bk_sub   = 1'b1;
                sat_next     = sat_reg | stat.bk_sat;
                out_row_next = ROW_W'(row_reg);
                final_next   = (row_reg == '0);
                status_next  = sat_next ? ST_SAT : ST_OK;
                state_next   = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read the previous row while sweeping forward, the current one while substituting back
    always_comb
    begin
        case (state_reg)
            S_IDLE:          addr_full = rows_reg - CW'(1);
            S_BMUL, S_BSUB:  addr_full = row_reg;
            default:         addr_full = row_reg - CW'(1);
        endcase
    end

    assign rd_addr = addr_full[AW-1:0];
    assign wr_addr = row_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rows_reg  <= '0;
            err_reg   <= ST_OK;
            row_reg   <= '0;
            last_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            err_reg   <= err_next;
            row_reg   <= row_next;
            last_reg  <= last_next;
            sat_reg   <= sat_next;
            final_reg <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg <= out_row_next;
        status_reg  <= status_next;
    end

    assign res_row    = out_row_reg;
    assign res_final  = final_reg;
    assign res_status = status_reg;
endmodule

// ===== hdl/tridiagonal_system_solver_top.sv =====
// Thomas-algorithm solver for tridiagonal systems in signed fixed point (FRAC_BITS fraction
// bits, Q16.16 by default). Rows arrive one item each; the forward sweep runs per row, and
// the two bit-serial dividers form the modified super-diagonal and right-hand side in
// parallel. The row flagged last starts back substitution, which emits one solution item at
// a time, the next only after the previous one is accepted, from the highest row down to row
// 0; row 0 carries final_value. Status 2 flags saturation, 1 a zero pivot and 3 more than
// MAX_ROWS rows; on a zero pivot or too many rows a single item with row 0 is emitted.
module tridiagonal_system_solver_top #(
    parameter int MAX_ROWS  = tds_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    tds_row_if.sink   rows,
    tds_res_if.source results
);
    import tds_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    tds_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .row_valid(rows.valid), .row_last(rows.last_row), .row_ready(rows.ready),
        .res_valid(results.valid), .res_ready(results.ready),
        .res_row(results.row_index), .res_final(results.final_value),
        .res_status(results.status),
        .cmd(cmd), .stat(stat), .rd_addr(rd_addr), .wr_addr(wr_addr)
    );

    tds_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .rd_addr(rd_addr), .wr_addr(wr_addr),
        .sub_diag(rows.sub_diag), .main_diag(rows.main_diag),
        .super_diag(rows.super_diag), .rhs_value(rows.rhs_value),
        .solution(results.solution)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rows.ready && results.valid))
        else $error("row intake open while a result is pending");

    a_final_row0: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.final_value) |-> (results.row_index == '0))
        else $error("final item not on row 0");

    a_error_item: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.status == ST_PIVOT || results.status == ST_ROWS))
        |-> (results.final_value && results.solution == '0))
        else $error("error item malformed");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.final_value) |=> rows.ready)
        else $error("not ready after end of run");
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

typedef struct {
    bit signed [31:0] sub_diag;
    bit signed [31:0] main_diag;
    bit signed [31:0] super_diag;
    bit signed [31:0] rhs_value;
    bit               last_row;
} row_item_t;

typedef struct {
    bit [5:0]         row_index;
    bit signed [31:0] solution;
    bit               final_value;
    bit [1:0]         status;
} solution_item_t;

class thomas_scoreboard;
    localparam int FRAC = tds_pkg::FRAC_BITS_DEF;
    localparam int DEPTH = tds_pkg::MAX_ROWS_DEF;

    bit signed [31:0] fwd_super[DEPTH];
    bit signed [31:0] fwd_rhs[DEPTH];
    int unsigned      row_count;
    bit [1:0]         sys_error;
    solution_item_t   pending_solutions[$];
    int               mismatches;

    function bit signed [31:0] clamp(longint v, inout bit sat);
        if (v > longint'(32'sh7fff_ffff))
        begin
            sat = 1;
            return 32'sh7fff_ffff;
        end
        if (v < -longint'(64'sh8000_0000))
        begin
            sat = 1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // product rounded toward minus infinity
    function bit signed [31:0] fx_mul(bit signed [31:0] a, bit signed [31:0] b, inout bit sat);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp(p >>> FRAC, sat);
    endfunction

    function bit signed [31:0] fx_sub(bit signed [31:0] a, bit signed [31:0] b, inout bit sat);
        return clamp(longint'(a) - longint'(b), sat);
    endfunction

    function bit signed [31:0] fx_div(bit signed [31:0] num, bit signed [31:0] den,
                                      inout bit sat);
        longint n;
        n = longint'(num) * (longint'(1) << FRAC);
        return clamp(n / longint'(den), sat);
    endfunction

    function void push(bit [5:0] idx, bit signed [31:0] x, bit fin, bit [1:0] st);
        solution_item_t s;
        s.row_index = idx;
        s.solution = x;
        s.final_value = fin;
        s.status = st;
        pending_solutions.push_back(s);
    endfunction

    function bit is_fatal();
        return sys_error == tds_pkg::ST_PIVOT || sys_error == tds_pkg::ST_ROWS;
    endfunction

    // forward sweep of one accepted row, back substitution on the last one
    function void note_row(row_item_t r);
        bit               fatal;
        bit               sat;
        bit signed [31:0] den;
        bit signed [31:0] num;
        bit signed [31:0] x;
        bit signed [31:0] prod;
        int unsigned      i;
        fatal = is_fatal();
        sat = 0;
        if (row_count >= DEPTH)
        begin
            if (!fatal)
                sys_error = tds_pkg::ST_ROWS;
            fatal = 1;
        end
        else
        begin
            i = row_count;
            if (!fatal)
            begin
                den = r.main_diag;
                num = r.rhs_value;
                if (i > 0)
                begin
                    prod = fx_mul(r.sub_diag, fwd_super[i-1], sat);
                    den = fx_sub(r.main_diag, prod, sat);
                    prod = fx_mul(r.sub_diag, fwd_rhs[i-1], sat);
                    num = fx_sub(r.rhs_value, prod, sat);
                end
                if (den == 0)
                begin
                    sys_error = tds_pkg::ST_PIVOT;
                    fatal = 1;
                end
                else
                begin
                    fwd_super[i] = fx_div(r.super_diag, den, sat);
                    fwd_rhs[i] = fx_div(num, den, sat);
                    if (sat && sys_error == tds_pkg::ST_OK)
                        sys_error = tds_pkg::ST_SAT;
                end
            end
            row_count = i + 1;
        end
        if (!r.last_row)
            return;
        if (fatal)
            push(6'd0, 32'sd0, 1'b1, sys_error);
        else
        begin
            sat = (sys_error == tds_pkg::ST_SAT);
            i = row_count - 1;
            x = fwd_rhs[i];
            push(6'(i), x, i == 0, sat ? tds_pkg::ST_SAT : tds_pkg::ST_OK);
            while (i > 0)
            begin
                i--;
                prod = fx_mul(fwd_super[i], x, sat);
                x = fx_sub(fwd_rhs[i], prod, sat);
                push(6'(i), x, i == 0, sat ? tds_pkg::ST_SAT : tds_pkg::ST_OK);
            end
        end
        row_count = 0;
        sys_error = tds_pkg::ST_OK;
    endfunction

    function void check_solution(solution_item_t got);
        solution_item_t want;
        if (pending_solutions.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: row %0d x %0d final %0d status %0d",
                         got.row_index, got.solution, got.final_value, got.status);
            return;
        end
        want = pending_solutions.pop_front();
        if (got.row_index != want.row_index || got.solution != want.solution ||
            got.final_value != want.final_value || got.status != want.status)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected row %0d x %0d final %0d status %0d, ",
                         want.row_index, want.solution, want.final_value, want.status,
                         "got row %0d x %0d final %0d status %0d",
                         got.row_index, got.solution, got.final_value, got.status);
        end
    endfunction
endclass

module testbench;
    localparam int IDLE_LIMIT = 6000;
    localparam int ROW_TARGET = 370;
    localparam bit signed [31:0] ONE = 32'sh0001_0000;
    localparam bit signed [31:0] QMAX = 32'sh7fff_ffff;
    localparam bit signed [31:0] QMIN = 32'sh8000_0000;

    logic clk = 0;
    logic rst_n = 0;

    tds_row_if rows ();
    tds_res_if results ();

    tridiagonal_system_solver_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .rows    (rows.sink),
        .results (results.source)
    );

    thomas_scoreboard solutions_sb = new();
    int  rows_sent;
    int  idle_cycles;
    int  burst_left;
    int  hold_request;
    bit  stim_done;

    always #5 clk = ~clk;

    initial
    begin
        rows.valid = 0;
        rows.sub_diag = 0;
        rows.main_diag = 0;
        rows.super_diag = 0;
        rows.rhs_value = 0;
        rows.last_row = 0;
        results.ready = 0;
    end

    // receiver: stall patterns and one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int phase;
        int hold_left;
        mode = 0;
        mode_left = 0;
        phase = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 0;
            end
            else if (mode == 0)
                results.ready <= 1;
            else if (mode == 1)
                results.ready <= $urandom_range(0, 1);
            else
                results.ready <= (phase % 4) != 0;
        end
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        solution_item_t got;
        if (rst_n)
        begin
            if (results.valid && results.ready)
            begin
                got.row_index = results.row_index;
                got.solution = results.solution;
                got.final_value = results.final_value;
                got.status = results.status;
                solutions_sb.check_solution(got);
            end
            if ((results.valid && results.ready) || (rows.valid && rows.ready))
                idle_cycles = 0;
            else if (!stim_done || solutions_sb.pending_solutions.size() > 0)
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    task automatic send_row(row_item_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                rows.valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rows.valid <= 1;
        rows.sub_diag <= r.sub_diag;
        rows.main_diag <= r.main_diag;
        rows.super_diag <= r.super_diag;
        rows.rhs_value <= r.rhs_value;
        rows.last_row <= r.last_row;
        do
            @(posedge clk);
        while (!rows.ready);
        solutions_sb.note_row(r);
        rows_sent++;
    endtask

    task automatic send_fields(bit signed [31:0] a, bit signed [31:0] b, bit signed [31:0] c,
                               bit signed [31:0] d, bit last);
        row_item_t r;
        r.sub_diag = a;
        r.main_diag = b;
        r.super_diag = c;
        r.rhs_value = d;
        r.last_row = last;
        send_row(r);
    endtask

    function automatic bit signed [31:0] small_coef(int whole);
        bit signed [31:0] v;
        v = $urandom_range(0, whole * 65536);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // kind 0: diagonally dominant, 1: raw random, 2: zero pivot planted
    task automatic send_system(int n, int kind);
        int bad;
        bad = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (kind == 1)
                send_fields($urandom, $urandom, $urandom, $urandom, i == n - 1);
            else if (kind == 2 && i == bad)
                send_fields(i == 0 ? small_coef(1) : 0, 0, small_coef(1), small_coef(50),
                            i == n - 1);
            else
                send_fields(small_coef(1), ONE * $urandom_range(3, 9) * ($urandom_range(0, 1)
                            ? 1 : -1) + $urandom_range(0, 65535), small_coef(1),
                            small_coef(400), i == n - 1);
        end
    endtask

    initial
    begin
        int pick;
        bit big_done;
        bit over_done;
        rows_sent = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_request = 0;
        stim_done = 0;
        big_done = 0;
        over_done = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send_fields(0, ONE, 0, 3 * ONE, 1);
        send_fields(QMAX, QMIN, QMAX, QMAX, 1);
        send_fields(QMIN, 1, QMIN, QMAX, 1);
        send_fields(-1, -1, -1, -1, 1);
        send_fields(QMIN, QMIN, QMIN, QMIN, 1);
        send_fields(0, 0, ONE, ONE, 0);
        send_fields(ONE, ONE, 0, ONE, 1);
        send_fields(0, 2 * ONE, ONE, ONE, 0);
        send_fields(0, 0, ONE, ONE, 0);
        send_fields(ONE, ONE, 0, ONE, 1);
        send_fields(ONE, 4 * ONE, ONE, 5 * ONE, 0);
        send_fields(ONE, 4 * ONE, ONE, 6 * ONE, 0);
        send_fields(ONE, 4 * ONE, ONE, 5 * ONE, 1);
        send_fields(0, ONE, QMAX, QMAX, 0);
        send_fields(QMAX, ONE, 0, QMIN, 1);
        send_fields(ONE, QMAX, ONE, 1, 1);

        // block fills while the receiver holds off
        hold_request = 800;
        while (rows_sent < ROW_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (!big_done && rows_sent > 120)
            begin
                send_system(64, 0);
                big_done = 1;
            end
            else if (!over_done && rows_sent > 220)
            begin
                send_system(66, 0);
                over_done = 1;
            end
            else if (pick < 75)
                send_system($urandom_range(1, 6), 0);
            else if (pick < 88)
                send_system($urandom_range(1, 4), 1);
            else
                send_system($urandom_range(1, 5), 2);
        end
        rows.valid <= 0;
        stim_done = 1;

        while (solutions_sb.pending_solutions.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (solutions_sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
